FILE: rtl/shrr_pkg.sv
// Package for the SHiP/RRIP stream-aware replacement unit.
// Holds sizes, derived widths and the packed row types; no dependencies.
package shrr_pkg;
  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int SIG_BITS      = 6;
  localparam int LEADER_COUNT  = 64;
  localparam int SELECTOR_BITS = 10;
  localparam int ADDR_BITS     = 48;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_BITS;

  localparam logic [1:0] AGE_MAX = 2'd3;
  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_INIT = SEL_MAX >> 1;
  localparam logic [ADDR_BITS-1:0] LINE_STRIDE = ADDR_BITS'(64);
  localparam logic [ADDR_BITS-1:0] NEG_STRIDE = ADDR_BITS'(0) - LINE_STRIDE;
  localparam logic [SET_W-1:0] SRRIP_LIMIT = SET_W'(LEADER_COUNT);
  localparam logic [SET_W-1:0] BRRIP_BASE = SET_W'(NUM_SETS - LEADER_COUNT);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

  localparam logic [1:0] TYPE_LOAD = 2'd0;

  typedef struct packed {
    logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig;
    logic [NUM_WAYS-1:0][1:0]          age;
  } line_row_t;

  typedef struct packed {
    logic [1:0]           cnt;
    logic [ADDR_BITS-1:0] last;
  } stride_row_t;
endpackage

FILE: rtl/ship_rrip_stream_replacement_unit.sv
// Top level of the SHiP/RRIP stream-aware replacement unit.
// Depends on shrr_pkg for sizes and row types.
//
// One cache access is taken per start pulse while busy is low. Busy stays high
// through S_LOOK (stride update, reuse read), S_RU1 (reuse update on a hit,
// reuse read on a miss) and S_RU2 (row write back, reuse update on a miss).
// Out_valid rises for one cycle as busy falls, with the chosen way, the stream
// flag and the written age. The receiver cannot stall results. After reset a
// clearing pass over the 2048 set rows, one row per cycle, holds busy high.
module ship_rrip_stream_replacement_unit
  import shrr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [SET_W-1:0]     in_set_index,
  input  logic                 in_hit,
  input  logic [WAY_W-1:0]     in_hit_way,
  input  logic [ADDR_BITS-1:0] in_pc,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [1:0]           in_access_type,
  output logic                 out_valid,
  output logic [WAY_W-1:0]     out_chosen_way,
  output logic                 out_stream_seen,
  output logic [1:0]           out_new_age
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_LOOK, S_RU1, S_RU2} state_t;

  state_t                   st_r;
  logic [SET_W-1:0]         clr_cnt_r, set_r;
  logic                     hit_r, stream_r, stream_nxt;
  logic [WAY_W-1:0]         way_r, way_nxt;
  logic [SIG_BITS-1:0]      sig_r, lsig_r, lsig_nxt;
  logic [ADDR_BITS-1:0]     addr_r;
  logic [1:0]               atype_r, inc_r;
  logic                     hr_r, hr_nxt;
  logic [SELECTOR_BITS-1:0] sel_r, sel_nxt;
  line_row_t                row_r, row_nxt, row_wr;
  logic                     out_valid_r;
  logic [WAY_W-1:0]         out_way_r;
  logic                     out_stream_r;
  logic [1:0]               out_age_r, age_nxt;

  line_row_t   line_mem [NUM_SETS];
  stride_row_t strd_mem [NUM_SETS];
  logic [1:0]  reuse_mem [SIG_COUNT];
  line_row_t   line_rd;
  stride_row_t strd_rd, strd_wdata;
  logic [1:0]  ru_rd, ru_wdata;
  logic [SIG_BITS-1:0] ru_raddr, ru_waddr;
  logic        line_we, strd_we, ru_we;
  logic [SET_W-1:0] mem_addr;

  logic [1:0]  top;
  logic [1:0]  lift;
  logic        found;
  logic [ADDR_BITS-1:0] diff;
  logic [1:0]  cnt_new;
  logic        srrip_leader, brrip_leader, srrip_pick, accept;

  assign accept = start && (st_r == S_IDLE);
  assign busy = (st_r != S_IDLE);
  assign mem_addr = (st_r == S_CLR) ? clr_cnt_r : (accept ? in_set_index : set_r);

  always_ff @(posedge clk) begin
    if (line_we) line_mem[mem_addr] <= row_wr;
    if (strd_we) strd_mem[mem_addr] <= strd_wdata;
    line_rd <= line_mem[mem_addr];
    strd_rd <= strd_mem[mem_addr];
    if (ru_we) reuse_mem[ru_waddr] <= ru_wdata;
    ru_rd <= reuse_mem[ru_raddr];
  end

  // Stride detection and victim search on the row just read.
  always_comb begin
    diff = addr_r - strd_rd.last;
    if (strd_rd.last == '0) begin
      cnt_new = strd_rd.cnt;
      stream_nxt = 1'b0;
    end else begin
      if (diff == LINE_STRIDE || diff == NEG_STRIDE)
        cnt_new = (strd_rd.cnt == 2'd3) ? 2'd3 : strd_rd.cnt + 2'd1;
      else
        cnt_new = 2'd0;
      stream_nxt = cnt_new[1];
    end
    top = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (line_rd.age[w] > top) top = line_rd.age[w];
    lift = AGE_MAX - top;
    row_nxt = line_rd;
    way_nxt = '0;
    found = 1'b0;
    if (hit_r) begin
      way_nxt = way_r;
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_nxt.age[w] = line_rd.age[w] + lift;
        if (!found && line_rd.age[w] == top) begin
          found = 1'b1;
          way_nxt = WAY_W'(w);
        end
      end
    end
    lsig_nxt = line_rd.sig[way_nxt];
  end

  always_comb begin
    srrip_leader = set_r < SRRIP_LIMIT;
    brrip_leader = !srrip_leader && set_r >= BRRIP_BASE;
    srrip_pick = srrip_leader || (!brrip_leader && sel_r >= SEL_INIT);
    hr_nxt = hr_r;
    if (hit_r)
      hr_nxt = (sig_r == lsig_r) ? (inc_r == AGE_MAX) : (ru_rd == AGE_MAX);
    if (hit_r) age_nxt = 2'd0;
    else if (stream_r) age_nxt = AGE_MAX;
    else if (hr_r || srrip_pick) age_nxt = AGE_MAX - 2'd1;
    else age_nxt = AGE_MAX;
    row_wr = row_r;
    row_wr.age[way_r] = age_nxt;
    if (!hit_r) row_wr.sig[way_r] = sig_r;
    sel_nxt = sel_r;
    if (hit_r && !stream_r && !hr_nxt && atype_r == TYPE_LOAD) begin
      if (srrip_leader && sel_r != SEL_MAX) sel_nxt = sel_r + 1'b1;
      else if (brrip_leader && sel_r != '0) sel_nxt = sel_r - 1'b1;
    end
    line_we = 1'b0;
    strd_we = 1'b0;
    ru_we = 1'b0;
    strd_wdata = '{cnt: cnt_new, last: addr_r};
    ru_waddr = lsig_r;
    ru_wdata = CNT_ONE;
    ru_raddr = sig_r;
    case (st_r)
      S_CLR: begin
        line_we = 1'b1;
        strd_we = 1'b1;
        ru_we = 1'b1;
        row_wr = '{sig: '0, age: {NUM_WAYS{AGE_MAX}}};
        strd_wdata = '0;
        ru_waddr = clr_cnt_r[SIG_BITS-1:0];
      end
      S_LOOK: begin
        strd_we = 1'b1;
        ru_raddr = hit_r ? lsig_nxt : sig_r;
      end
      S_RU1: begin
        if (hit_r) begin
          ru_we = 1'b1;
          ru_wdata = (ru_rd == AGE_MAX) ? AGE_MAX : ru_rd + 2'd1;
          ru_raddr = sig_r;
        end else begin
          ru_raddr = lsig_r;
        end
      end
      S_RU2: begin
        line_we = 1'b1;
        if (!hit_r) begin
          ru_we = 1'b1;
          ru_wdata = (ru_rd == 2'd0) ? 2'd0 : ru_rd - 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_cnt_r <= '0;
      sel_r <= SEL_INIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_SET) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            set_r <= in_set_index;
            hit_r <= in_hit;
            way_r <= in_hit_way;
            sig_r <= in_pc[SIG_BITS+1:2];
            addr_r <= in_address;
            atype_r <= in_access_type;
            st_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          stream_r <= stream_nxt;
          way_r <= way_nxt;
          lsig_r <= lsig_nxt;
          row_r <= row_nxt;
          st_r <= S_RU1;
        end
        S_RU1: begin
          inc_r <= (ru_rd == AGE_MAX) ? AGE_MAX : ru_rd + 2'd1;
          hr_r <= (ru_rd == AGE_MAX);
          st_r <= S_RU2;
        end
        S_RU2: begin
          sel_r <= sel_nxt;
          out_valid_r <= 1'b1;
          out_way_r <= way_r;
          out_stream_r <= stream_r;
          out_age_r <= age_nxt;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_chosen_way = out_way_r;
  assign out_stream_seen = out_stream_r;
  assign out_new_age = out_age_r;

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == S_LOOK) else $error("accepted item did not start");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> st_r == S_IDLE) else $error("result while busy");
  a_hit_age: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RU2 && hit_r) |=> out_new_age == 2'd0) else $error("hit age not zero");
endmodule

FILE: tb/tb.sv
// Self-checking testbench for ship_rrip_stream_replacement_unit.
// Drives cache accesses through the start/busy port and checks every result
// against an in-bench model of the replacement policy; depends on shrr_pkg.
module tb;
  import shrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WAY_W-1:0] way;
    logic             stream;
    logic [1:0]       age;
  } pick_t;

  class replacement_scoreboard;
    logic [1:0]             ages [NUM_SETS*NUM_WAYS];
    logic [SIG_BITS-1:0]    sigs [NUM_SETS*NUM_WAYS];
    logic [1:0]             reuse [SIG_COUNT];
    logic [1:0]             stride [NUM_SETS];
    logic [ADDR_BITS-1:0]   prev_addr [NUM_SETS];
    logic [SELECTOR_BITS-1:0] selector;
    pick_t                  pending [$];
    int                     errors;
    int                     checked;

    function new();
      foreach (ages[i]) ages[i] = AGE_MAX;
      foreach (sigs[i]) sigs[i] = '0;
      foreach (reuse[i]) reuse[i] = CNT_ONE;
      foreach (stride[i]) stride[i] = '0;
      foreach (prev_addr[i]) prev_addr[i] = '0;
      selector = SEL_INIT;
      errors = 0;
      checked = 0;
    endfunction

    function void note_access(logic [SET_W-1:0] set, logic hit, logic [WAY_W-1:0] hway,
                              logic [ADDR_BITS-1:0] pc, logic [ADDR_BITS-1:0] addr,
                              logic [1:0] atype);
      int base;
      logic [SIG_BITS-1:0] sig;
      logic [SIG_BITS-1:0] vsig;
      logic srl;
      logic brl;
      logic strm;
      logic hi;
      logic use_s;
      logic [ADDR_BITS-1:0] diff;
      logic [1:0] top;
      logic [1:0] age;
      int way;
      pick_t p;
      base = int'(set) * NUM_WAYS;
      sig = pc[SIG_BITS+1:2];
      srl = set < SRRIP_LIMIT;
      brl = !srl && set >= BRRIP_BASE;
      strm = 0;
      if (prev_addr[set] != '0) begin
        diff = addr - prev_addr[set];
        if (diff == LINE_STRIDE || diff == NEG_STRIDE) begin
          if (stride[set] != 2'd3) stride[set]++;
        end else begin
          stride[set] = '0;
        end
        strm = stride[set] >= 2'd2;
      end
      prev_addr[set] = addr;
      if (hit) begin
        way = hway;
        age = '0;
        ages[base+way] = '0;
        if (reuse[sigs[base+way]] != AGE_MAX) reuse[sigs[base+way]]++;
        hi = reuse[sig] == AGE_MAX;
      end else begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++) if (ages[base+w] > top) top = ages[base+w];
        for (int w = 0; w < NUM_WAYS; w++) ages[base+w] += AGE_MAX - top;
        way = 0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) if (ages[base+w] == AGE_MAX) way = w;
        hi = reuse[sig] == AGE_MAX;
        vsig = sigs[base+way];
        if (reuse[vsig] != 0) reuse[vsig]--;
        sigs[base+way] = sig;
        use_s = srl ? 1'b1 : brl ? 1'b0 : (selector >= SEL_INIT);
        if (strm) age = AGE_MAX;
        else if (hi || use_s) age = 2'd2;
        else age = AGE_MAX;
        ages[base+way] = age;
      end
      if (hit && !strm && !hi && atype == TYPE_LOAD) begin
        if (srl && selector != SEL_MAX) selector++;
        else if (brl && selector != '0) selector--;
      end
      p.way = WAY_W'(way);
      p.stream = strm;
      p.age = age;
      pending.push_back(p);
    endfunction

    function void check_result(logic [WAY_W-1:0] way, logic strm, logic [1:0] age);
      pick_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result way=%0d", way);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (way !== e.way) begin
        $error("chosen_way expected %0d actual %0d", e.way, way);
        errors++;
      end
      if (strm !== e.stream) begin
        $error("stream_seen expected %0d actual %0d", e.stream, strm);
        errors++;
      end
      if (age !== e.age) begin
        $error("new_age expected %0d actual %0d", e.age, age);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [SET_W-1:0]     in_set_index;
  logic                 in_hit;
  logic [WAY_W-1:0]     in_hit_way;
  logic [ADDR_BITS-1:0] in_pc;
  logic [ADDR_BITS-1:0] in_address;
  logic [1:0]           in_access_type;
  logic                 out_valid;
  logic [WAY_W-1:0]     out_chosen_way;
  logic                 out_stream_seen;
  logic [1:0]           out_new_age;

  replacement_scoreboard sb;
  int cycles = 0;
  int sent;

  ship_rrip_stream_replacement_unit DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_chosen_way, out_stream_seen, out_new_age);
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_access(logic [SET_W-1:0] set, logic hit, logic [WAY_W-1:0] hway,
                             logic [ADDR_BITS-1:0] pc, logic [ADDR_BITS-1:0] addr,
                             logic [1:0] atype);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (sent % 100 < 15) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_set_index <= set;
    in_hit <= hit;
    in_hit_way <= hway;
    in_pc <= pc;
    in_address <= addr;
    in_access_type <= atype;
    do @(posedge clk); while (busy);
    sb.note_access(set, hit, hway, pc, addr, atype);
    sent++;
  endtask

  function automatic logic [ADDR_BITS-1:0] rand48();
    return ADDR_BITS'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    case ($urandom_range(0, 3))
      0: return SET_W'($urandom_range(0, LEADER_COUNT - 1));
      1: return BRRIP_BASE + SET_W'($urandom_range(0, LEADER_COUNT - 1));
      2: return SET_W'($urandom_range(LEADER_COUNT, 80));
      default: return SET_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [ADDR_BITS-1:0] a;
    logic [SET_W-1:0] s;
    int n;
    sb = new();
    sent = 0;
    rst_n = 0;
    start = 0;
    in_set_index = '0;
    in_hit = 0;
    in_hit_way = '0;
    in_pc = '0;
    in_address = '0;
    in_access_type = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    send_access('0, 0, '0, '0, '0, TYPE_LOAD);
    send_access(LAST_SET, 0, '1, '1, '1, 2'd3);
    send_access(LAST_SET, 1, '1, '1, 48'd63, 2'd2);
    send_access(LAST_SET, 1, '1, '1, 48'd127, TYPE_LOAD);
    send_access(LAST_SET, 0, '1, '1, 48'd191, 2'd1);
    send_access(LAST_SET, 0, '0, '1, 48'd127, 2'd1);
    send_access(LAST_SET, 1, 4'd3, '1, 48'd5000, TYPE_LOAD);
    for (int i = 0; i < 6; i++) send_access(SET_W'(5), 1, 4'd0, 48'h4, 48'h1000, TYPE_LOAD);
    for (int i = 0; i < 4; i++) send_access(SET_W'(2000), 1, 4'd1, 48'h8, 48'h2000, TYPE_LOAD);
    for (int i = 0; i < 5; i++) send_access(SET_W'(700), 0, '0, 48'h4, 48'h9000, 2'd1);

    while (sent < 1050) begin
      s = pick_set();
      a = rand48();
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
          send_access(s, $urandom_range(0, 1), WAY_W'($urandom()),
                      ADDR_BITS'($urandom_range(0, 7) << 2), a,
                      2'($urandom_range(0, 3)));
          a = $urandom_range(0, 1) ? a + 64 : a - 64;
        end
      end else begin
        send_access(s, $urandom_range(0, 2) != 0, WAY_W'($urandom()),
                    $urandom_range(0, 1) ? rand48() : ADDR_BITS'($urandom_range(0, 15) << 2),
                    ($urandom_range(0, 7) == 0) ? ADDR_BITS'(0) : a,
                    ($urandom_range(0, 1) ? TYPE_LOAD : 2'($urandom_range(0, 3))));
      end
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d accesses (hits, misses, strides, leader and follower sets);",
             sent);
    $display("checked %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
